@@ rtl/core/assert_macros.svh @@
// assert_macros.svh: concurrent assertion helpers for the core RTL.
// Depends on nothing; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication, disabled during reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same, without reset disable: must hold in reset too.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ rtl/core/fpsc_pkg.sv @@
// fpsc_pkg: types, constants and helpers for the scale-by-power-of-two core.
// No dependencies.
`default_nettype none
package fpsc_pkg;
	localparam logic [5:0] FL_INVALID   = 6'h01;
	localparam logic [5:0] FL_DENORMAL  = 6'h02;
	localparam logic [5:0] FL_OVERFLOW  = 6'h08;
	localparam logic [5:0] FL_UNDERFLOW = 6'h10;
	localparam logic [5:0] FL_PRECISION = 6'h20;
	localparam logic [5:0] FL_ALL       = 6'h3f;

	localparam logic [1:0] RND_NEAR = 2'd0;
	localparam logic [1:0] RND_DOWN = 2'd1;
	localparam logic [1:0] RND_UP   = 2'd2;
	localparam logic [1:0] RND_ZERO = 2'd3;
	localparam logic [2:0] RSEL_DEFAULT = 3'd4;

	localparam logic [1:0] REG_ROUNDING = 2'd0;
	localparam logic [1:0] REG_DAZ      = 2'd1;
	localparam logic [1:0] REG_FTZ      = 2'd2;
	localparam logic [1:0] REG_MASKS    = 2'd3;
	localparam int CFG_IDX_W = 8;

	localparam logic [31:0] SP_QUIET = 32'h0040_0000;
	localparam logic [31:0] SP_INDEF = 32'hffc0_0000;
	localparam logic [63:0] DP_QUIET = 64'h0008_0000_0000_0000;
	localparam logic [63:0] DP_INDEF = 64'hfff8_0000_0000_0000;
	localparam int SCALE_LIMIT = 32768;

	// Lane result classes decided in the front part.
	localparam logic [1:0] CLS_FIXED = 2'd0; // result known, no scaling
	localparam logic [1:0] CLS_SCALE = 2'd1; // finite nonzero x, scale it
	localparam logic [1:0] CLS_ZERO  = 2'd2; // inactive lane

	// Queue entry: one lane classified and ready for the back part.
	typedef struct packed {
		logic [1:0]  cls;
		logic        dbl;
		logic [63:0] fixed;     // result for CLS_FIXED
		logic        sign;
		logic [52:0] mant;      // normalized mantissa, leading one at bit 52
		logic signed [17:0] be; // biased exponent after scaling
		logic [1:0]  mode;
		logic        uf_masked;
		logic        supp;
		logic [5:0]  pre;
		logic        last;
	} lane_t;

	typedef struct packed {
		logic [63:0] res;
		logic [5:0]  flags;
		logic        last;
		logic        fault;
		logic [5:0]  sticky;
	} result_t;

	typedef struct packed {
		logic [1:0] rounding;
		logic       daz;
		logic       ftz;
		logic [5:0] masks;
	} cfg_t;
endpackage
`default_nettype wire

@@ rtl/core/fpsc_if.sv @@
// fpsc channel interfaces: valid/ready beats for lanes, results, config.
// Depends on fpsc_pkg.
`default_nettype none
interface fpsc_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] left_bits;
	logic [63:0] right_bits;
	logic        is_double;
	logic        lane_active;
	logic [2:0]  rounding_select;
	logic        suppress_exceptions;
	logic        last_lane;
	modport source(output valid, left_bits, right_bits, is_double, lane_active,
		rounding_select, suppress_exceptions, last_lane, input ready);
	modport sink(input valid, left_bits, right_bits, is_double, lane_active,
		rounding_select, suppress_exceptions, last_lane, output ready);
endinterface

interface fpsc_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_bits;
	logic [5:0]  lane_flags;
	logic        is_last;
	logic        fault;
	logic [5:0]  sticky_flags_out;
	modport source(output valid, result_bits, lane_flags, is_last, fault,
		sticky_flags_out, input ready);
	modport sink(input valid, result_bits, lane_flags, is_last, fault,
		sticky_flags_out, output ready);
endinterface

interface fpsc_cfg_if;
	logic        valid;
	logic        ready;
	logic [fpsc_pkg::CFG_IDX_W-1:0] index;
	logic [63:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/fp_scale_by_power_of_two_core.sv @@
// fp_scale_by_power_of_two_core: top level, lane scale x * 2^floor(y).
// Depends on fpsc_pkg, fpsc_if, fpsc_front, fpsc_queue, fpsc_back, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
// One single or double lane per beat gives x * 2^floor(y) with full IEEE
// special-case, DAZ/FTZ, rounding and flag handling. Throughput is one lane
// per clock while the output is not stalled; each lane passes the front
// register and the two-entry queue, then the back stage writes the output
// register. The back part owns the sticky and pending flag registers, so flag
// commits follow lane order. Config writes are always accepted and take effect
// next cycle; write them only while the block is idle.
module fp_scale_by_power_of_two_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	fpsc_in_if.sink     in_ch,
	fpsc_out_if.source  out_ch,
	fpsc_cfg_if.sink    cfg_ch
);
	fpsc_pkg::cfg_t    cfg_q;
	fpsc_pkg::lane_t   lane_c, lane_s1, qout;
	fpsc_pkg::result_t res_c;
	logic v_s1, q_full, q_ne, q_pop, out_v_q, out_free, in_fire;

	// config register file
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{rounding: fpsc_pkg::RND_NEAR, daz: 1'b0, ftz: 1'b0,
				masks: fpsc_pkg::FL_ALL};
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				8'(fpsc_pkg::REG_ROUNDING): cfg_q.rounding <= cfg_ch.data[1:0];
				8'(fpsc_pkg::REG_DAZ):      cfg_q.daz <= cfg_ch.data[0];
				8'(fpsc_pkg::REG_FTZ):      cfg_q.ftz <= cfg_ch.data[0];
				8'(fpsc_pkg::REG_MASKS):    cfg_q.masks <= cfg_ch.data[5:0];
				default: ;
			endcase
		end
	end

	fpsc_front u_front (
		.left_bits(in_ch.left_bits), .right_bits(in_ch.right_bits),
		.is_double(in_ch.is_double), .lane_active(in_ch.lane_active),
		.rounding_select(in_ch.rounding_select),
		.suppress_exceptions(in_ch.suppress_exceptions),
		.last_lane(in_ch.last_lane), .cfg(cfg_q), .lane(lane_c)
	);

	// front stage register; stalls only when the queue is full
	assign in_ch.ready = !v_s1 || !q_full;
	assign in_fire = in_ch.valid && in_ch.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (in_ch.ready) v_s1 <= in_ch.valid;
	end
	always_ff @(posedge clk) begin
		if (in_fire) lane_s1 <= lane_c;
	end

	fpsc_queue u_queue (
		.clk, .arst_n,
		.push(v_s1 && !q_full), .din(lane_s1), .full(q_full),
		.pop(q_pop), .dout(qout), .not_empty(q_ne)
	);

	assign out_free = !out_v_q || out_ch.ready;
	assign q_pop = q_ne && out_free;

	fpsc_back u_back (
		.clk, .arst_n, .lane(qout), .fire(q_pop), .cfg(cfg_q), .res(res_c)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (out_free) out_v_q <= q_pop;
	end
	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_ch.result_bits <= res_c.res;
			out_ch.lane_flags <= res_c.flags;
			out_ch.is_last <= res_c.last;
			out_ch.fault <= res_c.fault;
			out_ch.sticky_flags_out <= res_c.sticky;
		end
	end
	assign out_ch.valid = out_v_q;

	`ASSERT_CLK(a_fault_last, clk, arst_n, out_ch.valid |-> (!out_ch.fault || out_ch.is_last), "fault off last lane")
	`ASSERT_CLK(a_no_pop_stall, clk, arst_n, (out_ch.valid && !out_ch.ready) |-> !q_pop, "pop while output stalled")
	`ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !out_ch.valid, "valid in reset")
endmodule
`default_nettype wire

@@ rtl/core/fpsc_front.sv @@
// fpsc_front: classifies one lane (specials, DAZ, floor of y) per cycle.
// Depends on fpsc_pkg.
`default_nettype none
module fpsc_front (
	input  wire logic [63:0]           left_bits,
	input  wire logic [63:0]           right_bits,
	input  wire logic                  is_double,
	input  wire logic                  lane_active,
	input  wire logic [2:0]            rounding_select,
	input  wire logic                  suppress_exceptions,
	input  wire logic                  last_lane,
	input  wire fpsc_pkg::cfg_t        cfg,
	output fpsc_pkg::lane_t            lane
);
	logic [63:0] x, y, qbit, expo, fracm, indef, signm;
	logic xs, ys, xe0, ye0, xeo, yeo, xfz, yfz;
	logic xnan, ynan, xsnan, ysnan, xinf, yinf, xzero, xden;
	logic [10:0] xe, ye;
	logic [52:0] xm, ym;
	logic [5:0]  xlz;
	logic signed [17:0] xt, yt, sc;
	logic [5:0]  pre;
	logic [63:0] fixed;
	logic [1:0]  cls;
	logic [53:0] ip;
	logic        fnz;
	logic signed [17:0] ipv;
	logic [52:0] nm;

	always_comb begin
		if (is_double) begin
			x = left_bits; y = right_bits;
			qbit = fpsc_pkg::DP_QUIET; indef = fpsc_pkg::DP_INDEF;
			expo = 64'h7ff0_0000_0000_0000; fracm = 64'h000f_ffff_ffff_ffff;
			signm = 64'h8000_0000_0000_0000;
			xe = x[62:52]; ye = y[62:52];
			xs = x[63]; ys = y[63];
		end else begin
			x = {32'd0, left_bits[31:0]}; y = {32'd0, right_bits[31:0]};
			qbit = {32'd0, fpsc_pkg::SP_QUIET}; indef = {32'd0, fpsc_pkg::SP_INDEF};
			expo = 64'h7f80_0000; fracm = 64'h007f_ffff; signm = 64'h8000_0000;
			xe = {3'd0, x[30:23]}; ye = {3'd0, y[30:23]};
			xs = x[31]; ys = y[31];
		end
		xe0 = xe == 11'd0; ye0 = ye == 11'd0;
		xeo = is_double ? (xe == 11'h7ff) : (xe == 11'h0ff);
		yeo = is_double ? (ye == 11'h7ff) : (ye == 11'h0ff);
		xfz = (x & fracm) == 64'd0; yfz = (y & fracm) == 64'd0;
		pre = '0;
		xden = xe0 && !xfz;
		if (xden) begin
			if (cfg.daz) begin x = x & signm; xfz = 1'b1; end
			else pre = pre | fpsc_pkg::FL_DENORMAL;
		end
		if (cfg.daz && ye0 && !yfz) begin y = y & signm; yfz = 1'b1; end
		xnan = xeo && !xfz; ynan = yeo && !yfz;
		xsnan = xnan && ((x & qbit) == 64'd0);
		ysnan = ynan && ((y & qbit) == 64'd0);
		xinf = xeo && xfz; yinf = yeo && yfz;
		xzero = xe0 && xfz;
		if (xsnan || ysnan) pre = pre | fpsc_pkg::FL_INVALID;
		cls = fpsc_pkg::CLS_FIXED;
		fixed = '0;
		if (xsnan) fixed = x | qbit;
		else if (ynan) fixed = xnan ? (x | qbit) : (y | qbit);
		else if (xnan) fixed = yinf ? (ys ? 64'd0 : expo) : (x | qbit);
		else if (yinf) begin
			if ((!ys && xzero) || (ys && xinf)) begin
				pre = pre | fpsc_pkg::FL_INVALID;
				fixed = indef;
			end else if (ys) fixed = xzero ? x : (xs ? signm : 64'd0);
			else fixed = xinf ? x : ((xs ? signm : 64'd0) | expo);
		end else if (xinf || xzero) fixed = x;
		else cls = fpsc_pkg::CLS_SCALE;
		if (!lane_active) begin
			cls = fpsc_pkg::CLS_ZERO;
			pre = '0;
		end
		// mantissas aligned with leading one at bit 52
		if (is_double) begin
			xm = {!xe0, x[51:0]};
			ym = {!ye0, y[51:0]};
			xt = $signed({7'd0, xe0 ? 11'd1 : xe}) - 18'sd1075;
			yt = $signed({7'd0, ye0 ? 11'd1 : ye}) - 18'sd1075;
		end else begin
			xm = {!xe0, x[22:0], 29'd0};
			ym = {!ye0, y[22:0], 29'd0};
			xt = $signed({7'd0, xe0 ? 11'd1 : xe}) - 18'sd150 - 18'sd29;
			yt = $signed({7'd0, ye0 ? 11'd1 : ye}) - 18'sd150 - 18'sd29;
		end
		// leading-zero count of x mantissa
		xlz = 6'd0;
		for (int i = 0; i < 53; i++) if (xm[i]) xlz = 6'(52 - i);
		nm = xm << xlz;
		// floor(y): y = ym * 2^yt
		ip = '0; fnz = 1'b0; ipv = '0;
		if (ym == 53'd0) sc = 18'sd0;
		else if (yt >= 18'sd0 || yt > -18'sd38) begin
			// |y| >= 2^15 once yt > -38 (leading bit >= 52+yt); saturate
			if (yt >= -18'sd37 && ym[52]) sc = ys ? -18'sd32768 : 18'sd32768;
			else begin
				ip = {1'b0, ym} >> (-yt);
				fnz = (ym & ~(53'h1f_ffff_ffff_ffff << (-yt))) != 53'd0;
				ipv = 18'(ip);
				sc = ys ? -(ipv + 18'(fnz)) : ipv;
				if (sc > 18'sd32768) sc = 18'sd32768;
				if (sc < -18'sd32768) sc = -18'sd32768;
			end
		end else begin
			ip = {1'b0, ym} >> (-yt);
			fnz = (yt < -18'sd52) ? 1'b1 :
				((ym & ~(53'h1f_ffff_ffff_ffff << (-yt))) != 53'd0);
			ipv = 18'(ip);
			sc = ys ? -(ipv + 18'(fnz)) : ipv;
		end
		lane.cls = cls;
		lane.dbl = is_double;
		lane.fixed = fixed;
		lane.sign = xs;
		lane.mant = nm;
		lane.be = xt - 18'(xlz) + 18'sd52
			+ (is_double ? 18'sd1023 : 18'sd127 + 18'sd0) + sc
			- (is_double ? 18'sd0 : 18'sd0);
		lane.mode = (rounding_select == fpsc_pkg::RSEL_DEFAULT) ? cfg.rounding :
			(rounding_select < fpsc_pkg::RSEL_DEFAULT ? rounding_select[1:0]
			: fpsc_pkg::RND_NEAR);
		lane.uf_masked = suppress_exceptions || cfg.masks[4];
		lane.supp = suppress_exceptions;
		lane.pre = pre;
		lane.last = last_lane;
	end
endmodule
`default_nettype wire

@@ rtl/core/fpsc_queue.sv @@
// fpsc_queue: two-entry FIFO of classified lanes between front and back.
// Depends on fpsc_pkg.
`default_nettype none
module fpsc_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire fpsc_pkg::lane_t   din,
	output logic                   full,
	input  wire logic              pop,
	output fpsc_pkg::lane_t        dout,
	output logic                   not_empty
);
	fpsc_pkg::lane_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
	assign full = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign dout = mem_q[rp_q];
endmodule
`default_nettype wire

@@ rtl/core/fpsc_back.sv @@
// fpsc_back: scales, rounds and commits flags; one lane per cycle when fire is high.
// Depends on fpsc_pkg.
`default_nettype none
module fpsc_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fpsc_pkg::lane_t   lane,
	input  wire logic              fire,
	input  wire fpsc_pkg::cfg_t    cfg,
	output fpsc_pkg::result_t      res
);
	logic [5:0]  sticky_q, pend_pre_q, pend_post_q;
	logic [5:0]  post, pre_n, post_n, sticky_n, unm;
	logic [63:0] r;
	logic        fault;
	logic [5:0]  sh;
	logic [52:0] kept, rem, m;
	logic [53:0] half;
	logic        inc, to_inf, neg;
	logic signed [17:0] be;
	logic [63:0] signm, expo;
	logic [52:0] kr;

	always_comb begin
		neg = lane.sign;
		signm = lane.dbl ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
		expo = lane.dbl ? 64'h7ff0_0000_0000_0000 : 64'h7f80_0000;
		// single mantissa lives in the top 24 bits of mant
		m = lane.dbl ? lane.mant : {29'd0, lane.mant[52:29]};
		be = lane.be;
		post = '0; r = '0; inc = 1'b0; sh = '0; kept = '0; rem = '0; half = '0;
		to_inf = 1'b0; kr = '0;
		unique case (lane.cls)
			fpsc_pkg::CLS_ZERO: r = '0;
			fpsc_pkg::CLS_FIXED: r = lane.fixed;
			fpsc_pkg::CLS_SCALE: begin
				if (be >= (lane.dbl ? 18'sd2047 : 18'sd255)) begin
					to_inf = lane.mode == fpsc_pkg::RND_NEAR
						|| (lane.mode == fpsc_pkg::RND_UP && !neg)
						|| (lane.mode == fpsc_pkg::RND_DOWN && neg);
					post = fpsc_pkg::FL_OVERFLOW | fpsc_pkg::FL_PRECISION;
					r = (neg ? signm : 64'd0) | (to_inf ? expo : expo - 64'd1);
				end else if (be >= 18'sd1) begin
					r = lane.dbl ? {neg, be[10:0], m[51:0]}
						: {32'd0, neg, be[7:0], m[22:0]};
				end else begin
					if (be < (lane.dbl ? -18'sd53 : -18'sd24))
						sh = lane.dbl ? 6'd54 : 6'd25;
					else sh = 6'(18'sd1 - be);
					kept = m >> sh;
					rem = m & ~(53'h1f_ffff_ffff_ffff << sh);
					// half may reach 2^53 on a double lane, one bit past rem
					half = 54'd1 << (sh - 6'd1);
					if (rem != 53'd0) begin
						post = fpsc_pkg::FL_UNDERFLOW | fpsc_pkg::FL_PRECISION;
						unique case (lane.mode)
							fpsc_pkg::RND_NEAR: inc = ({1'b0, rem} > half) ||
								({1'b0, rem} == half && kept[0]);
							fpsc_pkg::RND_DOWN: inc = neg;
							fpsc_pkg::RND_UP:   inc = !neg;
							default:            inc = 1'b0;
						endcase
					end
					kr = kept + 53'(inc);
					r = (neg ? signm : 64'd0) | {11'd0, kr};
					// FTZ: still denormal after rounding
					if (post[4] && cfg.ftz && lane.uf_masked &&
						kr[lane.dbl ? 52 : 23] == 1'b0)
						r = neg ? signm : 64'd0;
				end
			end
			default: r = '0;
		endcase
		pre_n = pend_pre_q | (lane.supp ? 6'd0 : lane.pre);
		post_n = pend_post_q | (lane.supp || lane.cls != fpsc_pkg::CLS_SCALE ? 6'd0 : post);
		unm = ~cfg.masks & fpsc_pkg::FL_ALL;
		sticky_n = sticky_q; fault = 1'b0;
		if (lane.last) begin
			sticky_n = sticky_q | pre_n;
			if ((pre_n & unm) != 6'd0) fault = 1'b1;
			else begin
				sticky_n = sticky_n | post_n;
				fault = (post_n & unm) != 6'd0;
			end
		end
		res.res = r;
		res.flags = lane.pre | (lane.cls == fpsc_pkg::CLS_SCALE ? post : 6'd0);
		res.last = lane.last;
		res.fault = fault;
		res.sticky = sticky_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sticky_q <= '0; pend_pre_q <= '0; pend_post_q <= '0;
		end else if (fire) begin
			sticky_q <= sticky_n;
			pend_pre_q <= lane.last ? 6'd0 : pre_n;
			pend_post_q <= lane.last ? 6'd0 : post_n;
		end
	end
endmodule
`default_nettype wire

@@ tb/sv/fpsc_tb_pkg.sv @@
`timescale 1ns / 1ps
// fpsc_tb_pkg: lane-level predictor of the scale-by-power-of-two core.
// Depends on fpsc_pkg for flag and rounding codes, NaN constants and the scale limit.
package fpsc_tb_pkg;
	import fpsc_pkg::*;

	typedef struct {
		int unsigned prec;
		int          bias;
		int          exp_ones;
		logic [63:0] sgn, expo, frac, quiet, indef, width;
	} fmt_s;

	typedef struct packed {
		logic [63:0] res;
		logic [5:0]  flags;
		logic        last;
		logic        fault;
		logic [5:0]  sticky;
	} lane_res_t;

	function automatic fmt_s fmt_of(input logic dbl);
		fmt_s f;
		if (dbl) begin
			f.prec = 52; f.bias = 1023; f.exp_ones = 2047;
			f.sgn = 64'h8000_0000_0000_0000; f.expo = 64'h7ff0_0000_0000_0000;
			f.frac = 64'h000f_ffff_ffff_ffff; f.quiet = DP_QUIET; f.indef = DP_INDEF;
			f.width = '1;
		end else begin
			f.prec = 23; f.bias = 127; f.exp_ones = 255;
			f.sgn = 64'h8000_0000; f.expo = 64'h7f80_0000; f.frac = 64'h007f_ffff;
			f.quiet = {32'd0, SP_QUIET}; f.indef = {32'd0, SP_INDEF};
			f.width = 64'hffff_ffff;
		end
		return f;
	endfunction

	function automatic bit f_nan(logic [63:0] v, fmt_s f);
		return (v & f.expo) == f.expo && (v & f.frac) != 0;
	endfunction
	function automatic bit f_snan(logic [63:0] v, fmt_s f);
		return f_nan(v, f) && (v & f.quiet) == 0;
	endfunction
	function automatic bit f_inf(logic [63:0] v, fmt_s f);
		return (v & ~f.sgn & f.width) == f.expo;
	endfunction
	function automatic bit f_zero(logic [63:0] v, fmt_s f);
		return (v & ~f.sgn & f.width) == 0;
	endfunction
	function automatic bit f_den(logic [63:0] v, fmt_s f);
		return (v & f.expo) == 0 && (v & f.frac) != 0;
	endfunction

	// v = m * 2^t for finite v
	function automatic void split(input logic [63:0] v, input fmt_s f,
			output logic [63:0] m, output int t);
		logic [63:0] e;
		e = (v & f.expo) >> f.prec;
		if (e == 0) begin
			m = v & f.frac;
			t = 1 - f.bias - int'(f.prec);
		end else begin
			m = (v & f.frac) | (64'd1 << f.prec);
			t = int'(e) - f.bias - int'(f.prec);
		end
	endfunction

	function automatic int floor_exp(logic [63:0] y, fmt_s f);
		logic [63:0] m, ip, fnz;
		int t, sh;
		longint r;
		bit neg;
		neg = (y & f.sgn) != 0;
		split(y, f, m, t);
		if (m == 0) return 0;
		if (t >= 0) return neg ? -SCALE_LIMIT : SCALE_LIMIT;
		sh = -t;
		if (sh >= 64) begin
			ip = 0; fnz = 1;
		end else begin
			ip = m >> sh;
			fnz = (m & ((64'd1 << sh) - 1)) != 0;
		end
		r = neg ? -longint'(ip + fnz) : longint'(ip);
		if (r > SCALE_LIMIT) r = SCALE_LIMIT;
		if (r < -SCALE_LIMIT) r = -SCALE_LIMIT;
		return int'(r);
	endfunction

	function automatic logic [63:0] scaled(logic [63:0] x, int sc, logic [1:0] mode,
			fmt_s f, ref logic [5:0] post);
		logic [63:0] m, s, top, kept, rem, half, inc;
		int t, be, sh;
		bit neg, to_inf;
		s = x & f.sgn; top = 64'd1 << f.prec; neg = s != 0; inc = 0;
		split(x, f, m, t);
		while ((m & top) == 0) begin
			m <<= 1; t--;
		end
		be = t + int'(f.prec) + f.bias + sc;
		if (be >= f.exp_ones) begin
			to_inf = mode == RND_NEAR || (mode == RND_UP && !neg) || (mode == RND_DOWN && neg);
			post |= FL_OVERFLOW | FL_PRECISION;
			return s | (to_inf ? f.expo : f.expo - 1);
		end
		if (be >= 1) return s | (64'(be) << f.prec) | (m & f.frac);
		sh = 1 - be;
		if (sh > int'(f.prec) + 2) sh = int'(f.prec) + 2;
		kept = m >> sh;
		rem = m & ((64'd1 << sh) - 1);
		half = 64'd1 << (sh - 1);
		if (rem != 0) begin
			post |= FL_UNDERFLOW | FL_PRECISION;
			case (mode)
				RND_NEAR: inc = (rem > half || (rem == half && kept[0])) ? 1 : 0;
				RND_DOWN: inc = neg ? 1 : 0;
				RND_UP:   inc = neg ? 0 : 1;
				default:  inc = 0;
			endcase
		end
		return s | (kept + inc);
	endfunction

	function automatic logic [63:0] lane_value(logic [63:0] xi, logic [63:0] yi, fmt_s f,
			logic [1:0] mode, bit uf_masked, bit daz, bit ftz,
			ref logic [5:0] pre, ref logic [5:0] post);
		logic [63:0] x, y, r;
		bit xn, yn, xinf, xz, negs;
		x = xi; y = yi;
		if (f_den(x, f)) begin
			if (daz) x &= f.sgn;
			else pre |= FL_DENORMAL;
		end
		if (daz && f_den(y, f)) y &= f.sgn;
		xn = f_nan(x, f); yn = f_nan(y, f);
		if (f_snan(x, f) || f_snan(y, f)) pre |= FL_INVALID;
		if (f_snan(x, f)) return x | f.quiet;
		if (yn) return xn ? (x | f.quiet) : (y | f.quiet);
		if (xn) begin
			if (f_inf(y, f)) return (y & f.sgn) != 0 ? 64'd0 : f.expo;
			return x | f.quiet;
		end
		xinf = f_inf(x, f); xz = f_zero(x, f);
		if (f_inf(y, f)) begin
			negs = (y & f.sgn) != 0;
			if ((!negs && xz) || (negs && xinf)) begin
				pre |= FL_INVALID;
				return f.indef;
			end
			if (negs) return xz ? x : (x & f.sgn);
			return xinf ? x : ((x & f.sgn) | f.expo);
		end
		if (xinf || xz) return x;
		r = scaled(x, floor_exp(y, f), mode, f, post);
		if ((post & FL_UNDERFLOW) != 0 && f_den(r, f) && ftz && uf_masked) r &= f.sgn;
		return r;
	endfunction
endpackage

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for fp_scale_by_power_of_two_core.
// Depends on fpsc_pkg, fpsc_if, fpsc_tb_pkg and the core RTL.
module tb;
	import fpsc_pkg::*;
	import fpsc_tb_pkg::*;

	typedef struct packed {
		logic [63:0] l, r;
		logic        dbl, act;
		logic [2:0]  rsel;
		logic        supp, last;
	} lane_in_t;

	logic clk = 0;
	logic arst_n = 0;
	always #5 clk = ~clk;

	fpsc_in_if  in_ch();
	fpsc_out_if out_ch();
	fpsc_cfg_if cfg_ch();

	fp_scale_by_power_of_two_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
	);

	// Shadow of the block's registers and flag state.
	logic [1:0] dflt_rnd;
	logic       daz_on, ftz_on;
	logic [5:0] masks, sticky, pend_pre, pend_post;

	lane_in_t  lane_q[$];     // lanes waiting for the driver
	lane_res_t expect_q[$];   // predicted results, oldest first
	int errors = 0, lanes_sent = 0, results_seen = 0, faults_seen = 0;
	bit stim_done = 0;

	// Predict one accepted lane and advance the shadow flag state.
	function automatic lane_res_t predict_lane(lane_in_t b);
		fmt_s f;
		lane_res_t o;
		logic [63:0] x, y;
		logic [5:0] pre, post, unm;
		logic [1:0] mode;
		bit fault;
		f = fmt_of(b.dbl);
		x = b.l & f.width; y = b.r & f.width;
		pre = 0; post = 0; fault = 0; unm = ~masks & FL_ALL;
		if (b.rsel == RSEL_DEFAULT) mode = dflt_rnd;
		else if (b.rsel < RSEL_DEFAULT) mode = b.rsel[1:0];
		else mode = RND_NEAR;       // reserved selects round to nearest
		o.res = 0;
		if (b.act) begin
			o.res = lane_value(x, y, f, mode, b.supp || masks[4], daz_on, ftz_on,
				pre, post) & f.width;
			if (!b.supp) begin
				pend_pre |= pre;
				pend_post |= post;
			end
		end
		if (b.last) begin
			// pre flags first; an unmasked one drops the post set
			sticky |= pend_pre;
			if ((pend_pre & unm) != 0) fault = 1;
			else begin
				sticky |= pend_post;
				if ((pend_post & unm) != 0) fault = 1;
			end
			pend_pre = 0; pend_post = 0;
		end
		o.flags = pre | post;
		o.last = b.last;
		o.fault = fault;
		o.sticky = sticky;
		return o;
	endfunction

	// Driver: bursts of beats with random gaps.
	int burst_left = 0, gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 0;
			burst_left = 0; gap_left = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expect_q.push_back(predict_lane(lane_q.pop_front()));
				lanes_sent++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) gap_left--;
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 30);
					if ($urandom_range(0, 3) != 0) gap_left = $urandom_range(1, 6);
				end
				if (lane_q.size() > 0 && (burst_left > 0 && gap_left == 0 ||
						burst_left > 0 && $urandom_range(0, 1))) begin
					in_ch.valid <= 1;
					in_ch.left_bits <= lane_q[0].l;
					in_ch.right_bits <= lane_q[0].r;
					in_ch.is_double <= lane_q[0].dbl;
					in_ch.lane_active <= lane_q[0].act;
					in_ch.rounding_select <= lane_q[0].rsel;
					in_ch.suppress_exceptions <= lane_q[0].supp;
					in_ch.last_lane <= lane_q[0].last;
					burst_left--;
				end else in_ch.valid <= 0;
			end
		end
	end

	// Monitor: receiver stalls on its own rotating pattern.
	logic [15:0] stall_pat = 16'hffff;
	always @(posedge clk or negedge arst_n) begin
		lane_res_t e;
		if (!arst_n) begin
			out_ch.ready <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (expect_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %h", $time, out_ch.result_bits);
				end else begin
					e = expect_q.pop_front();
					faults_seen += e.fault;
					if (out_ch.result_bits !== e.res) begin
						errors++;
						$display("%0t: result_bits exp %h got %h", $time, e.res,
							out_ch.result_bits);
					end
					if (out_ch.lane_flags !== e.flags) begin
						errors++;
						$display("%0t: lane_flags exp %h got %h", $time, e.flags,
							out_ch.lane_flags);
					end
					if (out_ch.is_last !== e.last) begin
						errors++;
						$display("%0t: is_last exp %b got %b", $time, e.last, out_ch.is_last);
					end
					if (out_ch.fault !== e.fault) begin
						errors++;
						$display("%0t: fault exp %b got %b", $time, e.fault, out_ch.fault);
					end
					if (out_ch.sticky_flags_out !== e.sticky) begin
						errors++;
						$display("%0t: sticky exp %h got %h", $time, e.sticky,
							out_ch.sticky_flags_out);
					end
				end
			end
			if ($urandom_range(0, 63) == 0)
				stall_pat <= (stall_pat == 16'hffff) ? 16'($urandom) : 16'hffff;
			else stall_pat <= {stall_pat[14:0], stall_pat[15]};
			out_ch.ready <= stall_pat[0];
		end
	end

	// Config writes happen only while idle.
	task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1;
		cfg_ch.index <= CFG_IDX_W'(idx);
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 0;
		case (idx)
			REG_ROUNDING: dflt_rnd = val[1:0];
			REG_DAZ:      daz_on = val[0];
			REG_FTZ:      ftz_on = val[0];
			REG_MASKS:    masks = val[5:0];
		endcase
	endtask

	task automatic drain();
		while (lane_q.size() > 0 || expect_q.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Operand generator biased toward interesting encodings.
	function automatic logic [63:0] pick_bits(logic dbl);
		fmt_s f;
		logic [63:0] v, s;
		f = fmt_of(dbl);
		v = {$urandom, $urandom};
		s = v & f.sgn;
		case ($urandom_range(0, 11))
			0: v = s;                                   // zero
			1: v = s | f.expo;                          // infinity
			2: v = s | f.expo | f.quiet | (v & f.frac); // qnan
			3: v = s | f.expo | ((v & f.frac & ~f.quiet) | 1); // snan
			4: v = s | (v & f.frac);                    // denormal
			5: v = s | (64'(f.bias + $urandom_range(0, 12)) << f.prec) | (v & f.frac);
			6: v = s | (64'(f.bias - $urandom_range(0, 3)) << f.prec) | (v & f.frac);
			7: v = s | (64'($urandom_range(1, 6)) << f.prec) | (v & f.frac);
			8: v = s | ((f.expo - (64'd1 << f.prec)) | (v & f.frac)); // near max
			default: ;
		endcase
		// keep the unused upper half noisy on single lanes
		return dbl ? v : ({$urandom, 32'd0} | (v & f.width));
	endfunction

	function automatic lane_in_t rand_lane(bit last);
		lane_in_t b;
		b.dbl = $urandom_range(0, 1);
		b.l = pick_bits(b.dbl);
		b.r = pick_bits(b.dbl);
		b.act = $urandom_range(0, 7) != 0;
		b.rsel = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
		b.supp = $urandom_range(0, 5) == 0;
		b.last = last;
		return b;
	endfunction

	function automatic lane_in_t mk(logic [63:0] l, logic [63:0] r, logic dbl,
			logic [2:0] rsel, logic last);
		lane_in_t b;
		b.l = l; b.r = r; b.dbl = dbl; b.act = 1; b.rsel = rsel; b.supp = 0; b.last = last;
		return b;
	endfunction

	initial begin
		int n;
		lane_in_t b;
		in_ch.valid = 0; in_ch.left_bits = 0; in_ch.right_bits = 0; in_ch.is_double = 0;
		in_ch.lane_active = 0; in_ch.rounding_select = 0; in_ch.suppress_exceptions = 0;
		in_ch.last_lane = 0; out_ch.ready = 0;
		cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
		dflt_rnd = RND_NEAR; daz_on = 0; ftz_on = 0; masks = FL_ALL;
		sticky = 0; pend_pre = 0; pend_post = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// Directed: specials, tiny/overflow, every rounding mode, the default and a reserved select.
		lane_q.push_back(mk(64'h3f80_0000, 64'h4000_0000, 0, 0, 0));        // 1*4
		lane_q.push_back(mk(64'h0000_0001, 64'h3f80_0000, 0, 0, 0));        // denorm x
		lane_q.push_back(mk(64'h7f80_0001, 64'h3f80_0000, 0, 0, 0));        // snan x
		lane_q.push_back(mk(64'h3f80_0000, 64'h7fc0_0001, 0, 0, 0));        // qnan y
		lane_q.push_back(mk(64'h7fc0_0000, 64'hff80_0000, 0, 0, 0));        // qnan x, -inf y
		lane_q.push_back(mk(64'h0000_0000, 64'h7f80_0000, 0, 0, 0));        // 0*2^inf
		lane_q.push_back(mk(64'hff80_0000, 64'hff80_0000, 0, 0, 0));        // inf*2^-inf
		lane_q.push_back(mk(64'h7f7f_ffff, 64'h4700_0000, 0, 1, 0));        // overflow down
		lane_q.push_back(mk(64'hff7f_ffff, 64'h4700_0000, 0, 2, 0));        // overflow up
		lane_q.push_back(mk(64'h3fff_ffff, 64'hc2fe_0000, 0, 0, 0));        // tiny to min normal
		lane_q.push_back(mk(64'h3f80_0000, 64'hc318_0000, 0, 3, 0));        // tiny below the smallest denormal, round to zero
		lane_q.push_back(mk(64'hbfc0_0000, 64'hc316_0000, 0, 4, 0));        // default round
		lane_q.push_back(mk(64'h3fc0_0000, 64'hbfc0_0000, 0, 7, 1));        // reserved, y<0 frac
		lane_q.push_back(mk(64'h7fef_ffff_ffff_ffff, 64'h40f0_0000_0000_0000, 1, 0, 0));
		lane_q.push_back(mk(64'h0000_0000_0000_0001, 64'hc0f0_0000_0000_0000, 1, 2, 0));
		lane_q.push_back(mk(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1, 0, 0));
		lane_q.push_back(mk(64'h7ff0_0000_0000_0001, 64'h7ff0_0000_0000_0000, 1, 0, 0));
		b = mk(64'h3ff0_0000_0000_0000, 64'h0, 1, 0, 1); b.act = 0;
		lane_q.push_back(b);
		drain();

		// Phases: cycle the registers through extremes, random instructions each.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin cfg_write(REG_MASKS, 6'h00); cfg_write(REG_ROUNDING, RND_ZERO); end
				1: begin cfg_write(REG_DAZ, 1); cfg_write(REG_FTZ, 1);
					cfg_write(REG_MASKS, FL_ALL); end
				2: begin cfg_write(REG_ROUNDING, RND_UP); cfg_write(REG_MASKS, 6'h2d); end
				3: begin cfg_write(REG_DAZ, 0); cfg_write(REG_ROUNDING, RND_DOWN);
					cfg_write(REG_MASKS, 6'h3e); end
				4: begin cfg_write(REG_FTZ, 0); cfg_write(REG_MASKS, 6'h2f);
					cfg_write(REG_ROUNDING, RND_NEAR); end
				default: begin cfg_write(REG_FTZ, 1); cfg_write(REG_MASKS, 6'h20);
					cfg_write(REG_DAZ, 0); end
			endcase
			n = 0;
			while (n < 72) begin
				int len;
				len = $urandom_range(1, 8);
				for (int k = 0; k < len; k++) lane_q.push_back(rand_lane(k == len - 1));
				n += len;
			end
			drain();
		end
		stim_done = 1;
		$display("covered %0d lanes, %0d results, %0d faulting instructions, 6 config phases",
			lanes_sent, results_seen, faults_seen);
		if (errors == 0) $display("fp_scale_by_power_of_two_core: match");
		else $display("fp_scale_by_power_of_two_core: mismatch");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("fp_scale_by_power_of_two_core: mismatch");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/fpsc_pkg.sv
rtl/core/fpsc_if.sv
rtl/core/fpsc_front.sv
rtl/core/fpsc_queue.sv
rtl/core/fpsc_back.sv
rtl/core/fp_scale_by_power_of_two_core.sv
tb/sv/fpsc_tb_pkg.sv
tb/sv/tb.sv
